/* sv/srripd_pkg.sv */
package srripd_pkg;

  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int ADDR_W   = 16;
  localparam int AGE_W    = 2;
  localparam int STREAK_W = 3;
  localparam int FILL_W   = 5;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;

  localparam logic [AGE_W-1:0]  AGE_MAX   = 2'd3;
  localparam logic [AGE_W-1:0]  AGE_NEW   = 2'd0;
  localparam logic [FILL_W-1:0] FILL_WRAP = 5'h1F;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [ADDR_W-1:0]   address_low;
    logic                was_hit;
    logic                leader;
    logic                first_half;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   last_address;
    logic [ADDR_W-1:0]   last_stride;
    logic [STREAK_W-1:0] streak;
  } stride_t;

endpackage

/* sv/srripd_if.sv */
interface srripd_in_if;
  import srripd_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [SET_IN_W-1:0] set_index;
  logic [WAY_IN_W-1:0] way_index;
  logic [ADDR_W-1:0]   address_low;
  logic                was_hit;

  modport source (output valid, op, set_index, way_index, address_low, was_hit,
                  input ready);
  modport sink (input valid, op, set_index, way_index, address_low, was_hit,
                output ready);
endinterface

interface srripd_out_if;
  import srripd_pkg::*;

  logic                valid;
  logic                ready;
  logic [WAY_IN_W-1:0] victim_way;
  logic                streaming_seen;

  modport source (output valid, victim_way, streaming_seen, input ready);
  modport sink (input valid, victim_way, streaming_seen, output ready);
endinterface

/* sv/srripd_ram.sv */
module srripd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/srripd_front.sv */
module srripd_front #(
  parameter int NUM_SETS     = 2048,
  parameter int LEADER_COUNT = 32
) (
  srripd_in_if.sink          in_chan,
  input  logic               q_full,
  input  logic               init_done,
  output logic               q_push,
  output srripd_pkg::item_t  q_item
);
  import srripd_pkg::*;

  localparam int SPACING  = NUM_SETS / LEADER_COUNT;
  localparam int HALF_SET = (LEADER_COUNT / 2) * SPACING;
  localparam int SET_LIM  = (1 << SET_IN_W) - 1;

  logic [SET_IN_W:0]   red;
  logic [SET_IN_W-1:0] set_mod;
  logic                leader;
  logic                first_half;

  // reduce the set index below NUM_SETS
  always_comb begin
    red = {1'b0, in_chan.set_index};
    for (int k = SET_IN_W - 1; k >= 0; k--) begin
      if ((NUM_SETS << k) <= SET_LIM) begin
        if (red >= (SET_IN_W + 1)'(NUM_SETS << k)) begin
          red = red - (SET_IN_W + 1)'(NUM_SETS << k);
        end
      end
    end
    set_mod = red[SET_IN_W-1:0];
  end

  always_comb begin
    leader = 1'b0;
    for (int n = 0; n < LEADER_COUNT; n++) begin
      if (32'(set_mod) == n * SPACING) begin
        leader = 1'b1;
      end
    end
    first_half = (SPACING == 0) || (32'(set_mod) < HALF_SET);
  end

  assign in_chan.ready = init_done && !q_full;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    q_item.op          = op_t'(in_chan.op);
    q_item.set_index   = set_mod;
    q_item.way_index   = in_chan.way_index;
    q_item.address_low = in_chan.address_low;
    q_item.was_hit     = in_chan.was_hit;
    q_item.leader      = leader;
    q_item.first_half  = first_half;
  end

endmodule

/* sv/srripd_queue.sv */
module srripd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srripd_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output srripd_pkg::item_t head,
  output logic              empty
);
  import srripd_pkg::*;

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;

  assign full  = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/srripd_back.sv */
module srripd_back #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int DUEL_BITS     = 10,
  parameter int STREAK_NEEDED = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  srripd_pkg::item_t q_head,
  output logic              q_pop,
  output logic              init_done,
  srripd_out_if.source      out_chan
);
  import srripd_pkg::*;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WORD_W = NUM_WAYS * AGE_W;
  localparam int ST_W   = $bits(stride_t);
  localparam logic [DUEL_BITS-1:0] DUEL_MAX = {DUEL_BITS{1'b1}};
  localparam logic [DUEL_BITS-1:0] DUEL_MID = DUEL_MAX >> 1;
  localparam logic [SET_W-1:0]     SET_LAST = SET_W'(NUM_SETS - 1);

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [SET_W-1:0]     init_cnt_r;
  item_t                cur_r;
  logic [DUEL_BITS-1:0] duel_r;
  logic [DUEL_BITS-1:0] duel_nxt;
  logic [FILL_W-1:0]    lfill_r;
  logic [FILL_W-1:0]    lfill_nxt;
  logic [FILL_W-1:0]    ffill_r;
  logic [FILL_W-1:0]    ffill_nxt;
  logic                 out_valid_r;
  logic [WAY_IN_W-1:0]  out_victim_r;
  logic                 out_stream_r;

  logic                 re;
  logic [SET_W-1:0]     raddr;
  logic                 age_we;
  logic                 st_we;
  logic [SET_W-1:0]     waddr;
  logic [WORD_W-1:0]    age_wdata;
  logic [ST_W-1:0]      st_wdata;
  logic [WORD_W-1:0]    age_rdata;
  logic [ST_W-1:0]      st_rdata;

  logic                 out_free;
  logic                 go;
  logic [NUM_WAYS-1:0][AGE_W-1:0] ages_old;
  logic [NUM_WAYS-1:0][AGE_W-1:0] ages_new;
  logic [AGE_W-1:0]     oldest;
  logic [AGE_W-1:0]     age_inc;
  logic [AGE_W-1:0]     ins_age;
  logic [WAY_IN_W-1:0]  victim;
  logic                 any3;
  logic                 any2;
  logic                 any1;
  logic                 way_ok;
  stride_t              st_old;
  stride_t              st_new;
  logic [ADDR_W-1:0]    stride;
  logic                 restart;
  logic                 streaming;

  srripd_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SETS)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (waddr),
    .wdata (age_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (age_rdata)
  );

  srripd_ram #(.WIDTH(ST_W), .DEPTH(NUM_SETS)) u_stride_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (st_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  assign out_free  = !out_valid_r || out_chan.ready;
  assign go        = (state_r == BK_EXEC) && out_free;
  assign init_done = (state_r != BK_INIT);

  always_comb begin
    case (state_r)
      BK_INIT: state_nxt = (init_cnt_r == SET_LAST) ? BK_IDLE : BK_INIT;
      BK_IDLE: state_nxt = q_empty ? BK_IDLE : BK_EXEC;
      BK_EXEC: state_nxt = out_free ? BK_IDLE : BK_EXEC;
      default: state_nxt = BK_INIT;
    endcase
  end

  // victim search and aging
  always_comb begin
    ages_old = age_rdata;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (ages_old[w] == 2'd3);
      any2 = any2 | (ages_old[w] == 2'd2);
      any1 = any1 | (ages_old[w] == 2'd1);
    end
    oldest  = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    age_inc = AGE_MAX - oldest;
    victim  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (ages_old[w] == oldest) begin
        victim = WAY_IN_W'(w);
      end
    end
  end

  // stride detector, duel counter, insertion age
  always_comb begin
    st_old  = stride_t'(st_rdata);
    stride  = cur_r.address_low - st_old.last_address;
    restart = (st_old.streak == '0) || (stride != st_old.last_stride) || (stride == '0);
    st_new.last_address = cur_r.address_low;
    st_new.last_stride  = stride;
    if (restart) begin
      st_new.streak = STREAK_W'(1);
    end else if (st_old.streak < STREAK_W'(STREAK_NEEDED)) begin
      st_new.streak = st_old.streak + 1'b1;
    end else begin
      st_new.streak = st_old.streak;
    end
    streaming = !restart && (st_new.streak >= STREAK_W'(STREAK_NEEDED));

    duel_nxt  = duel_r;
    lfill_nxt = lfill_r;
    ffill_nxt = ffill_r;
    ins_age   = AGE_MAX;
    if (cur_r.was_hit) begin
      ins_age = AGE_NEW;
      if (cur_r.leader) begin
        if (cur_r.first_half) begin
          if (duel_r != DUEL_MAX) begin
            duel_nxt = duel_r + 1'b1;
          end
        end else if (duel_r != '0) begin
          duel_nxt = duel_r - 1'b1;
        end
      end
    end else if (!streaming) begin
      if (cur_r.leader) begin
        if (!cur_r.first_half) begin
          lfill_nxt = (lfill_r + 1'b1) & FILL_WRAP;
          if (lfill_nxt == '0) begin
            ins_age = AGE_NEW;
          end
        end
      end else if (duel_r >= DUEL_MID) begin
        ffill_nxt = (ffill_r + 1'b1) & FILL_WRAP;
        if (ffill_nxt == '0) begin
          ins_age = AGE_NEW;
        end
      end
    end

    way_ok = 32'(cur_r.way_index) < NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (cur_r.op == OP_VICTIM) begin
        ages_new[w] = ages_old[w] + age_inc;
      end else if (way_ok && (32'(cur_r.way_index) == w)) begin
        ages_new[w] = ins_age;
      end else begin
        ages_new[w] = ages_old[w];
      end
    end
  end

  always_comb begin
    re        = 1'b0;
    raddr     = SET_W'(q_head.set_index);
    q_pop     = 1'b0;
    age_we    = 1'b0;
    st_we     = 1'b0;
    waddr     = SET_W'(cur_r.set_index);
    age_wdata = ages_new;
    st_wdata  = st_new;
    case (state_r)
      BK_INIT: begin
        age_we    = 1'b1;
        st_we     = 1'b1;
        waddr     = init_cnt_r;
        age_wdata = '1;
        st_wdata  = '0;
      end
      BK_IDLE: begin
        re    = !q_empty;
        q_pop = !q_empty;
      end
      BK_EXEC: begin
        age_we = out_free;
        st_we  = out_free && (cur_r.op == OP_UPDATE);
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      init_cnt_r  <= '0;
      duel_r      <= DUEL_MID;
      lfill_r     <= '0;
      ffill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_INIT) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
      if (go && (cur_r.op == OP_UPDATE)) begin
        duel_r  <= duel_nxt;
        lfill_r <= lfill_nxt;
        ffill_r <= ffill_nxt;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (go) begin
      out_victim_r <= (cur_r.op == OP_VICTIM) ? victim : '0;
      out_stream_r <= (cur_r.op == OP_UPDATE) && streaming;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.victim_way     = out_victim_r;
  assign out_chan.streaming_seen = out_stream_r;

endmodule

/* sv/srrip_dueling_stream_bypass.sv */
// channel   dir  handshake          payload
// in_chan   in   valid/ready        op, set_index, way_index, address_low, was_hit
// out_chan  out  valid/ready        victim_way, streaming_seen
//
// Each item goes through the back end in order: a set read (BK_IDLE), then the
// read-modify-write of the age and stride words (BK_EXEC). The registered read has no
// forwarding between items, so the next item is read only after this one is written.
// After reset a clearing pass writes every set before in_chan.ready rises.
// A two-entry queue decouples input acceptance from the back end; the output register
// holds a result under back-pressure while the next item waits in the queue.
module srrip_dueling_stream_bypass #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int LEADER_COUNT  = 32,
  parameter int DUEL_BITS     = 10,
  parameter int STREAK_NEEDED = 4
) (
  input logic          clk,
  input logic          rst_n,
  srripd_in_if.sink    in_chan,
  srripd_out_if.source out_chan
);
  import srripd_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  logic  init_done;
  item_t q_item;
  item_t q_head;

  srripd_front #(
    .NUM_SETS     (NUM_SETS),
    .LEADER_COUNT (LEADER_COUNT)
  ) u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .init_done (init_done),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  srripd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  srripd_back #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .DUEL_BITS     (DUEL_BITS),
    .STREAK_NEEDED (STREAK_NEEDED)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_chan  (out_chan)
  );

endmodule

/* tb/srrip_dueling_stream_bypass_tb.sv */
`timescale 1ns / 100ps

module srrip_dueling_stream_bypass_tb;
  import srripd_pkg::*;

  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int LEADER_COUNT  = 32;
  localparam int DUEL_BITS     = 10;
  localparam int STREAK_NEEDED = 4;
  localparam int SPACING       = NUM_SETS / LEADER_COUNT;

  localparam logic [DUEL_BITS-1:0] DUEL_TOP    = '1;
  localparam logic [DUEL_BITS-1:0] DUEL_MID_V  = DUEL_TOP >> 1;
  localparam logic [STREAK_W-1:0]  STREAK_FULL = STREAK_W'(STREAK_NEEDED);

  localparam int RANDOM_ITEMS = 1350;
  localparam int STREAMS      = 4;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_NS     = 400000;

  typedef enum {
    DRIFT_NONE,
    DRIFT_DOWN,
    DRIFT_UP
  } drift_t;

  typedef struct packed {
    op_t                 op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [ADDR_W-1:0]   address_low;
    logic                was_hit;
  } access_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] victim_way;
    logic                streaming_seen;
  } repl_result_t;

  class repl_scoreboard;
    logic [AGE_W-1:0]     way_age [NUM_SETS][NUM_WAYS];
    logic [ADDR_W-1:0]    prev_addr [NUM_SETS];
    logic [ADDR_W-1:0]    prev_stride [NUM_SETS];
    logic [STREAK_W-1:0]  streak [NUM_SETS];
    logic [DUEL_BITS-1:0] duel;
    logic [FILL_W-1:0]    leader_fills;
    logic [FILL_W-1:0]    follower_fills;
    logic [WAY_IN_W-1:0]  last_victim;
    repl_result_t         expected_results [$];
    int mismatches;
    int accepted;
    int checked;
    int agings;
    int stream_hits;
    int duel_low;
    int duel_high;

    function new();
      int s;
      int w;
      for (s = 0; s < NUM_SETS; s++) begin
        for (w = 0; w < NUM_WAYS; w++) way_age[s][w] = AGE_MAX;
        prev_addr[s]   = '0;
        prev_stride[s] = '0;
        streak[s]      = '0;
      end
      duel           = DUEL_MID_V;
      leader_fills   = '0;
      follower_fills = '0;
      last_victim    = '0;
      mismatches     = 0;
      accepted       = 0;
      checked        = 0;
      agings         = 0;
      stream_hits    = 0;
      duel_low       = int'(DUEL_MID_V);
      duel_high      = int'(DUEL_MID_V);
    endfunction

    function repl_result_t predict_access(access_t a);
      repl_result_t      r;
      logic [AGE_W-1:0]  oldest;
      logic [AGE_W-1:0]  age;
      logic [ADDR_W-1:0] stride;
      logic              streaming;
      logic              leader;
      logic              first_half;
      int                set;
      int                w;
      r   = '0;
      set = int'(a.set_index) % NUM_SETS;
      if (a.op == OP_VICTIM) begin
        oldest = '0;
        for (w = 0; w < NUM_WAYS; w++)
          if (way_age[set][w] > oldest) oldest = way_age[set][w];
        if (oldest != AGE_MAX) begin
          agings++;
          for (w = 0; w < NUM_WAYS; w++) way_age[set][w] = way_age[set][w] + (AGE_MAX - oldest);
        end
        for (w = NUM_WAYS - 1; w >= 0; w--)
          if (way_age[set][w] == AGE_MAX) r.victim_way = WAY_IN_W'(w);
        last_victim = r.victim_way;
        return r;
      end

      stride    = a.address_low - prev_addr[set];
      streaming = 1'b0;
      if (streak[set] == '0 || stride != prev_stride[set] || stride == '0) begin
        prev_stride[set] = stride;
        streak[set]      = STREAK_W'(1);
      end else begin
        if (streak[set] < STREAK_FULL) streak[set] = streak[set] + 1'b1;
        if (streak[set] >= STREAK_FULL) streaming = 1'b1;
      end
      prev_addr[set] = a.address_low;

      leader     = (set % SPACING == 0) && (set / SPACING < LEADER_COUNT);
      first_half = (set / SPACING) < (LEADER_COUNT / 2);
      if (a.was_hit) begin
        age = AGE_NEW;
        if (leader && first_half) begin
          if (duel != DUEL_TOP) duel = duel + 1'b1;
        end else if (leader) begin
          if (duel != '0) duel = duel - 1'b1;
        end
      end else begin
        age = AGE_MAX;
        if (!streaming) begin
          if (leader) begin
            if (!first_half) begin
              leader_fills = leader_fills + 1'b1;
              if (leader_fills == '0) age = AGE_NEW;
            end
          end else if (duel >= DUEL_MID_V) begin
            follower_fills = follower_fills + 1'b1;
            if (follower_fills == '0) age = AGE_NEW;
          end
        end
      end
      if (int'(a.way_index) < NUM_WAYS) way_age[set][int'(a.way_index)] = age;

      if (streaming) stream_hits++;
      if (int'(duel) < duel_low) duel_low = int'(duel);
      if (int'(duel) > duel_high) duel_high = int'(duel);
      r.streaming_seen = streaming;
      return r;
    endfunction

    function void note_access(access_t a);
      accepted++;
      expected_results.push_back(predict_access(a));
    endfunction

    function void check_result(logic [WAY_IN_W-1:0] victim, logic streaming);
      repl_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: victim_way %0d streaming_seen %0b",
               victim, streaming);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (e.victim_way !== victim) begin
        $error("victim_way expected %0d actual %0d", e.victim_way, victim);
        mismatches++;
      end
      if (e.streaming_seen !== streaming) begin
        $error("streaming_seen expected %0b actual %0b", e.streaming_seen, streaming);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  srripd_in_if  in_chan ();
  srripd_out_if out_chan ();

  srrip_dueling_stream_bypass #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .LEADER_COUNT  (LEADER_COUNT),
    .DUEL_BITS     (DUEL_BITS),
    .STREAK_NEEDED (STREAK_NEEDED)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  repl_scoreboard      sb;
  bit                  hold_off_req;
  bit                  fill_pending;
  logic [SET_IN_W-1:0] fill_set;
  access_t             plan_q [$];
  logic [SET_IN_W-1:0] stream_set [STREAMS];
  logic [ADDR_W-1:0]   stream_addr [STREAMS];
  logic [ADDR_W-1:0]   stream_stride [STREAMS];
  int                  stream_left [STREAMS];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic access_t make_access(op_t op, logic [SET_IN_W-1:0] set_idx,
                                          logic [WAY_IN_W-1:0] way,
                                          logic [ADDR_W-1:0] addr, logic hit);
    access_t a;
    a.op          = op;
    a.set_index   = set_idx;
    a.way_index   = way;
    a.address_low = addr;
    a.was_hit     = hit;
    return a;
  endfunction

  function automatic logic [SET_IN_W-1:0] pick_pool_set();
    case ($urandom_range(0, 5))
      0:       return SET_IN_W'(0);
      1:       return SET_IN_W'(1024);
      2:       return SET_IN_W'(1984);
      3:       return SET_IN_W'(448);
      4:       return SET_IN_W'(13);
      default: return SET_IN_W'(2047);
    endcase
  endfunction

  function automatic access_t leader_hit(logic up);
    int k;
    if (up) k = int'($urandom_range(0, LEADER_COUNT / 2 - 1));
    else k = int'($urandom_range(LEADER_COUNT / 2, LEADER_COUNT - 1));
    return make_access(OP_UPDATE, SET_IN_W'(k * SPACING), WAY_IN_W'($urandom_range(0, 15)),
                       ADDR_W'($urandom), 1'b1);
  endfunction

  task automatic gen_access(input drift_t drift, output access_t a);
    int                  roll;
    int                  k;
    int                  slot;
    logic [SET_IN_W-1:0] s;
    roll = int'($urandom_range(0, 99));
    if (fill_pending) begin
      fill_pending = 1'b0;
      a = make_access(OP_UPDATE, fill_set, sb.last_victim, ADDR_W'($urandom), 1'b0);
    end else if (plan_q.size() != 0) begin
      a = plan_q.pop_front();
    end else if (drift == DRIFT_DOWN && roll < 90) begin
      a = leader_hit(1'b0);
    end else if (drift == DRIFT_UP && roll < 55) begin
      a = leader_hit(1'b1);
    end else begin
      roll = int'($urandom_range(0, 99));
      if (roll < 20) begin
        if ($urandom_range(0, 1) == 0) s = pick_pool_set();
        else s = stream_set[$urandom_range(0, STREAMS - 1)];
        a = make_access(OP_VICTIM, s, WAY_IN_W'($urandom_range(0, 15)), ADDR_W'($urandom),
                        1'($urandom_range(0, 1)));
      end else if (roll < 42) begin
        slot = int'($urandom_range(0, STREAMS - 1));
        if (stream_left[slot] == 0) begin
          if ($urandom_range(0, 3) == 0)
            stream_set[slot] = SET_IN_W'($urandom_range(0, LEADER_COUNT - 1) * SPACING);
          else stream_set[slot] = SET_IN_W'($urandom_range(0, NUM_SETS - 1));
          stream_addr[slot] = ADDR_W'($urandom);
          k = int'($urandom_range(0, 9));
          if (k < 3) stream_stride[slot] = ADDR_W'($urandom_range(1, 8));
          else if (k == 3) stream_stride[slot] = '0;
          else if (k == 4) stream_stride[slot] = ADDR_W'(16'hFFFF - $urandom_range(0, 7));
          else stream_stride[slot] = ADDR_W'($urandom);
          stream_left[slot] = int'($urandom_range(3, 12));
        end
        stream_addr[slot] = stream_addr[slot] + stream_stride[slot];
        stream_left[slot]--;
        a = make_access(OP_UPDATE, stream_set[slot], WAY_IN_W'($urandom_range(0, 15)),
                        stream_addr[slot], 1'($urandom_range(0, 1)));
      end else if (roll < 62) begin
        a = make_access(OP_UPDATE, pick_pool_set(), WAY_IN_W'($urandom_range(0, 15)),
                        ADDR_W'($urandom), 1'($urandom_range(0, 9) < 7));
      end else if (roll < 76) begin
        a = leader_hit(1'($urandom_range(0, 1)));
      end else if (roll < 83) begin
        a = make_access(OP_UPDATE, SET_IN_W'($urandom_range(0, LEADER_COUNT - 1) * SPACING),
                        WAY_IN_W'($urandom_range(0, 15)), ADDR_W'($urandom), 1'b0);
      end else if (roll < 86) begin
        s = pick_pool_set();
        for (k = 0; k < NUM_WAYS; k++)
          plan_q.push_back(make_access(OP_UPDATE, s, WAY_IN_W'(k), ADDR_W'($urandom), 1'b1));
        plan_q.push_back(make_access(OP_VICTIM, s, '0, '0, 1'b0));
        a = plan_q.pop_front();
      end else begin
        a = make_access(op_t'($urandom_range(0, 1)), SET_IN_W'($urandom_range(0, NUM_SETS - 1)),
                        WAY_IN_W'($urandom_range(0, 15)), ADDR_W'($urandom),
                        1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic send_access(input access_t a, input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.op          <= a.op;
    in_chan.set_index   <= a.set_index;
    in_chan.way_index   <= a.way_index;
    in_chan.address_low <= a.address_low;
    in_chan.was_hit     <= a.was_hit;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_access(a);
  endtask

  initial begin : stimulus
    access_t directed_q [$];
    access_t a;
    drift_t  drift;
    int      idx;
    sb = new();
    hold_off_req = 1'b0;
    fill_pending = 1'b0;
    fill_set     = '0;
    foreach (stream_set[i]) stream_set[i] = '0;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.op          <= 1'b0;
    in_chan.set_index   <= '0;
    in_chan.way_index   <= '0;
    in_chan.address_low <= '0;
    in_chan.was_hit     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed_q.push_back(make_access(OP_VICTIM, 11'd0, 4'd0, 16'h0000, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd15, 16'hFFFF, 1'b1));
    directed_q.push_back(make_access(OP_VICTIM, 11'd5, 4'd0, 16'h0000, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd0, 16'hFFFE, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd1, 16'hFFFD, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd2, 16'hFFFC, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd3, 16'hFFFB, 1'b1));
    directed_q.push_back(make_access(OP_UPDATE, 11'd5, 4'd4, 16'hFFFB, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd1024, 4'd0, 16'h0000, 1'b1));
    directed_q.push_back(make_access(OP_UPDATE, 11'd7, 4'd0, 16'h1234, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd0, 4'd15, 16'hFFFF, 1'b1));
    directed_q.push_back(make_access(OP_UPDATE, 11'd7, 4'd1, 16'h1234, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd1984, 4'd0, 16'h8000, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd960, 4'd0, 16'h8000, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd2047, 4'd15, 16'h0000, 1'b1));
    directed_q.push_back(make_access(OP_VICTIM, 11'd2047, 4'd15, 16'hFFFF, 1'b1));
    directed_q.push_back(make_access(OP_VICTIM, 11'd5, 4'd0, 16'h0000, 1'b0));
    directed_q.push_back(make_access(OP_UPDATE, 11'd2047, 4'd0, 16'h0000, 1'b0));
    foreach (directed_q[i]) send_access(directed_q[i], int'($urandom_range(0, 7)));

    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx < 450) drift = DRIFT_NONE;
      else if (idx < 1050) drift = DRIFT_DOWN;
      else drift = DRIFT_UP;
      if (idx == 250 || idx == 1000) hold_off_req = 1'b1;
      if (idx == 700) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
      end
      gen_access(drift, a);
      if (a.op == OP_VICTIM && $urandom_range(0, 9) < 7) begin
        fill_pending = 1'b1;
        fill_set     = a.set_index;
      end
      send_access(a, (idx % 250 < 50) ? 0 : int'($urandom_range(0, 7)));
    end
    in_chan.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d accesses, %0d results checked, %0d set agings, %0d streaming updates",
             sb.accepted, sb.checked, sb.agings, sb.stream_hits);
    $display("summary: duel counter ranged %0d to %0d", sb.duel_low, sb.duel_high);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int rx_count;
    rx_count = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end else if (rx_count % 180 < 40) begin
        stall = 0;
      end else begin
        stall = int'($urandom_range(0, 7));
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      sb.check_result(out_chan.victim_way, out_chan.streaming_seen);
      rx_count++;
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/srripd_pkg.sv
sv/srripd_if.sv
sv/srripd_ram.sv
sv/srripd_front.sv
sv/srripd_queue.sv
sv/srripd_back.sv
sv/srrip_dueling_stream_bypass.sv
tb/srrip_dueling_stream_bypass_tb.sv
